// ===== design/tla_pkg.sv =====
package tla_pkg;

    localparam int CHAR_W = 8;    // received byte / line character
    localparam int LEN_W  = 6;    // line length and limit register

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 6'd63;

endpackage

// ===== design/tla_line_store.sv =====
module tla_line_store
    import tla_pkg::*;
#(
    parameter int LINE_STORE_BYTES = 64
)
(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(LINE_STORE_BYTES)-1:0] wr_addr,
    input  logic [CHAR_W-1:0]                   wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(LINE_STORE_BYTES)-1:0] rd_addr,
    output logic [CHAR_W-1:0]                   rd_data
);

    localparam int DEPTH = LINE_STORE_BYTES - 1;

    logic [CHAR_W-1:0] mem [0:DEPTH-1];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/tla_ctrl.sv =====
module tla_ctrl
    import tla_pkg::*;
#(
    parameter int LINE_STORE_BYTES = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_valid,
    input  logic [LEN_W-1:0]                    cfg_data,
    // input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [CHAR_W-1:0]                   s_tdata,
    // output beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [CHAR_W-1:0]                   m_char,
    output logic [LEN_W-1:0]                    m_len,
    output logic                                m_tlast,
    // line store
    output logic                                wr_en,
    output logic [$clog2(LINE_STORE_BYTES)-1:0] wr_addr,
    output logic [CHAR_W-1:0]                   wr_data,
    output logic                                rd_en,
    output logic [$clog2(LINE_STORE_BYTES)-1:0] rd_addr,
    input  logic [CHAR_W-1:0]                   rd_data
);

    localparam int FILL_W   = $clog2(LINE_STORE_BYTES);
    localparam int CAPACITY = LINE_STORE_BYTES - 1;
    localparam int CMP_W    = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    state_t              state_reg,       state_next;
    logic [FILL_W-1:0]   fill_reg,        fill_next;
    logic                ovf_reg,         ovf_next;
    logic [LEN_W-1:0]    limit_reg,       limit_next;
    logic [LEN_W-1:0]    lim_reg,         lim_next;
    logic [FILL_W-1:0]   rd_idx_reg,      rd_idx_next;
    logic                rd_pend_reg,     rd_pend_next;
    logic                rd_last_reg,     rd_last_next;
    logic                m_valid_reg,     m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg,      m_char_next;
    logic [LEN_W-1:0]    m_len_reg,       m_len_next;
    logic                m_last_reg,      m_last_next;

    logic                s_acc;
    logic [CMP_W-1:0]    fill_ext;
    logic [CMP_W-1:0]    limit_ext;
    logic [CMP_W-1:0]    lim_calc;
    logic [CMP_W-1:0]    idx_inc;
    logic                rd_is_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign fill_ext  = CMP_W'(fill_reg);
    assign limit_ext = CMP_W'(limit_reg);
    assign lim_calc  = (fill_ext < limit_ext) ? fill_ext : limit_ext;

    assign idx_inc    = CMP_W'(rd_idx_reg) + CMP_W'(1);
    assign rd_is_last = (idx_inc == CMP_W'(lim_reg));

    assign wr_addr = fill_reg;
    assign wr_data = s_tdata;
    assign rd_addr = rd_idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        limit_next   = limit_reg;
        lim_next     = lim_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_len_next   = m_len_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        if (s_acc)
        begin
            priority if (s_tdata == CH_CR)
            begin
                // dropped whenever accepted, never stored
            end
            else if (s_tdata == CH_LF)
            begin
                fill_next = '0;
                if (ovf_reg)
                begin
                    ovf_next = 1'b0;
                end
                else if (lim_calc != '0)
                begin
                    lim_next    = LEN_W'(lim_calc);
                    rd_idx_next = '0;
                    state_next  = ST_READ;
                end
            end
            else if (fill_reg >= FILL_W'(CAPACITY))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        // output register: drain, then refill from the landing read
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (rd_pend_reg)
        begin
            m_valid_next = 1'b1;
            m_char_next  = rd_data;
            m_len_next   = lim_reg;
            m_last_next  = rd_last_reg;
        end

        // issue a read only if its data will find the output register free
        if (state_reg == ST_READ && !rd_pend_reg && (!m_valid_reg || m_tready))
        begin
            rd_en        = 1'b1;
            rd_pend_next = 1'b1;
            rd_last_next = rd_is_last;
            rd_idx_next  = rd_idx_reg + FILL_W'(1);
            if (rd_is_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            limit_reg   <= LIMIT_RESET;
            lim_reg     <= '0;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_char_reg  <= '0;
            m_len_reg   <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            limit_reg   <= limit_next;
            lim_reg     <= lim_next;
            rd_idx_reg  <= rd_idx_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            m_valid_reg <= m_valid_next;
            m_char_reg  <= m_char_next;
            m_len_reg   <= m_len_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_len    = m_len_reg;
    assign m_tlast  = m_last_reg;

    a_land_into_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !m_valid_reg)
        else $error("read data landed on an occupied output register");

    a_no_rw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("store written and read in the same cycle");

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_reg) <= CMP_W'(CAPACITY))
        else $error("fill count beyond store capacity");

    a_read_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (CMP_W'(rd_idx_reg) < CMP_W'(lim_reg)))
        else $error("readout index past line length");

    a_last_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && rd_is_last) |=> (state_reg == ST_IDLE))
        else $error("readout did not stop after last character");

endmodule

// ===== design/text_line_assembler_unit.sv =====
// Text line assembler.
// s_* channel: one received byte per beat. Carriage return is dropped,
//   newline closes the line, any other byte is appended to the line store.
//   A byte that arrives with the store full sets an overflow mark; the line
//   is then thrown away silently at its newline.
// m_* channel: one beat per delivered character, in arrival order, with the
//   run length (truncated to the limit register) on every beat and tlast on
//   the final one. Empty and overflowed lines give no beats.
// cfg_* channel: writes the 6-bit per-line character limit (reset 63),
//   always ready; write it only while the block is idle.
// Throughput: a stored byte is taken every cycle. After a newline the
//   block stops taking bytes while it reads the line back: one store read
//   per character, each read issued only when the output register will be
//   free and no earlier read is still pending, so the readout cannot issue
//   a new store read before the previous one has landed.
// The output register lets the last character wait while new bytes come in.
// Reset clears fill count and overflow mark and sets the limit to 63; store
// contents are left as they are and only entries written for the current
// line are read. A receiver stall holds the output beat and pauses the readout.
module text_line_assembler_unit
    import tla_pkg::*;
#(
    parameter int LINE_STORE_BYTES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [LEN_W-1:0]          cfg_data,   // max_out_chars
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [CHAR_W-1:0]         s_tdata,    // [7:0] rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,    // [7:0] line_char, [13:8] line_length
    output logic                      m_tlast     // is_last
);

    localparam int ADDR_W = $clog2(LINE_STORE_BYTES);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CHAR_W-1:0] rd_data;
    logic [CHAR_W-1:0] m_char;
    logic [LEN_W-1:0]  m_len;

    // limit register never blocks a write
    assign cfg_ready = 1'b1;

    tla_ctrl #(
        .LINE_STORE_BYTES (LINE_STORE_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_char    (m_char),
        .m_len     (m_len),
        .m_tlast   (m_tlast),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // line store: one write port (byte append), one registered read port
    tla_line_store #(
        .LINE_STORE_BYTES (LINE_STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tdata = {2'b00, m_len, m_char};

endmodule

// ===== test/tb_text_line_assembler_unit.sv =====
`timescale 1ns / 1ps

module tb_text_line_assembler_unit;
    import tla_pkg::*;

    localparam int LINE_STORE_BYTES = 64;
    localparam int STORE_CAP        = LINE_STORE_BYTES - 1;
    localparam int LONG_HOLD        = 400;   // receiver hold-off, in cycles
    localparam int IDLE_SETTLE      = 12;    // newline-to-idle margin
    localparam int STALL_LIMIT      = 3000;  // cycles with no beat on any channel

    // One delivered character as the m_* side should show it.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              last;
    } line_beat_t;

    // One byte waiting to be sent; wait_drain holds it back until every
    // character already due has come out.
    typedef struct {
        logic [CHAR_W-1:0] data;
        logic              wait_drain;
    } rx_item_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata   = '0;     // [7:0] rx_byte
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;            // [7:0] line_char, [13:8] line_length
    logic              m_tlast;            // is_last

    rx_item_t   rx_pending[$];
    line_beat_t chars_due[$];

    // Shadow of the block's line state, advanced on every accepted beat.
    logic [CHAR_W-1:0] line_buf [0:STORE_CAP-1];
    int                line_fill     = 0;
    logic              line_overflow = 1'b0;
    logic [LEN_W-1:0]  char_limit    = LIMIT_RESET;

    int   error_count = 0;
    int   idle_cycles = 0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   hold_asked  = 0;
    int   hold_served = 0;
    logic steady      = 1'b0;   // no new random gaps on either side while set
    logic drain_next  = 1'b0;

    text_line_assembler_unit #(
        .LINE_STORE_BYTES (LINE_STORE_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 clk = ~clk;

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Mostly back to back, sometimes a few cycles, rarely a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Any byte that is neither CR nor LF.
    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_LF || c == CH_CR)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    // Line predictor: CR dropped, LF closes the line, anything else stored
    // unless the store is full, in which case the line is marked overflowed.
    task automatic assemble_rx_byte(input logic [CHAR_W-1:0] rx);
        int         n;
        int         run;
        line_beat_t b;
        if (rx == CH_CR)
        begin
            // never stored, never counted
        end
        else if (rx == CH_LF)
        begin
            n = line_fill;
            line_fill = 0;
            if (line_overflow)
                line_overflow = 1'b0;      // overflowed line dropped silently
            else
            begin
                run = (n < char_limit) ? n : int'(char_limit);
                for (int k = 0; k < run; k++)
                begin
                    b.ch   = line_buf[k];
                    b.len  = LEN_W'(run);
                    b.last = (k == run - 1);
                    chars_due.push_back(b);
                end
            end
        end
        else if (line_fill >= STORE_CAP)
            line_overflow = 1'b1;
        else
        begin
            line_buf[line_fill] = rx;
            line_fill++;
        end
    endtask

    task automatic queue_rx(input logic [CHAR_W-1:0] b);
        rx_item_t it;
        it.data       = b;
        it.wait_drain = drain_next;
        drain_next    = 1'b0;
        rx_pending.push_back(it);
    endtask

    // n text characters, CRs sprinkled in when asked, then LF.
    task automatic queue_line(input int n, input bit with_cr);
        for (int i = 0; i < n; i++)
        begin
            queue_rx(text_byte());
            if (with_cr && $urandom_range(0, 5) == 0)
                queue_rx(CH_CR);
        end
        queue_rx(CH_LF);
    endtask

    // Loose bytes, heavy on LF and CR: stray terminators and broken lines.
    task automatic queue_noise(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 7);
            if (r < 2)
                queue_rx(CH_LF);
            else if (r == 2)
                queue_rx(CH_CR);
            else
                queue_rx(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    function automatic int pick_line_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        else if (r < 90)
            return $urandom_range(9, 20);
        else
            return $urandom_range(21, 40);
    endfunction

    // Block is idle once nothing is queued or in flight and every character
    // has come out; the settle time covers lines that produce no output.
    task automatic wait_idle();
        while (rx_pending.size() != 0 || s_tvalid || chars_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Byte driver: pops the next byte once the previous beat is gone and the
    // random gap has run out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0 && !steady)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (rx_pending.size() != 0 &&
                     !(rx_pending[0].wait_drain && (s_tvalid || chars_due.size() != 0)))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_pending[0].data;
                void'(rx_pending.pop_front());
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the
    // output register and the readout back up into the byte input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_left  <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_served + 1;
            stall_left  <= LONG_HOLD;
            m_tready    <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
        begin
            stall_left <= pick_gap();
            m_tready   <= 1'b1;
        end
    end

    // Monitor: checks output beats against the oldest due character, then
    // feeds accepted bytes and limit writes into the predictor.
    always @(posedge clk)
    begin : line_monitor
        line_beat_t due;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (chars_due.size() == 0)
                    log_error($sformatf("unexpected beat char=%02h len=%0d last=%0b",
                                        m_tdata[7:0], m_tdata[13:8], m_tlast));
                else
                begin
                    due = chars_due.pop_front();
                    if (m_tdata[7:0] !== due.ch)
                        log_error($sformatf("line_char %02h, want %02h",
                                            m_tdata[7:0], due.ch));
                    if (m_tdata[13:8] !== due.len)
                        log_error($sformatf("line_length %0d, want %0d",
                                            m_tdata[13:8], due.len));
                    if (m_tlast !== due.last)
                        log_error($sformatf("is_last %0b, want %0b", m_tlast, due.last));
                end
            end
            if (s_tvalid && s_tready)
                assemble_rx_byte(s_tdata);
            if (cfg_valid && cfg_ready)
                char_limit = cfg_data;
        end
    end

    // Watchdog: too long with no beat anywhere means the block hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("tb_text_line_assembler_unit failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [LEN_W-1:0] phase_limit;
        int               start_count;
        int               line_len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset limit 63: byte extremes with a CR inside,
        // neighbors of the control codes, empty line, CR-only line,
        // single character line.
        queue_rx(8'h00);
        queue_rx(8'hFF);
        queue_rx(CH_CR);
        queue_rx(8'h0B);
        queue_rx(8'h0C);
        queue_rx(8'h0E);
        queue_rx(8'h09);
        queue_rx(CH_LF);
        queue_rx(CH_LF);
        queue_rx(CH_CR);
        queue_rx(CH_LF);
        queue_rx(8'h41);
        queue_rx(CH_LF);
        wait_idle();

        // Limit of one: truncation to a single character.
        write_limit(6'd1);
        queue_rx(8'h78);
        queue_rx(8'h79);
        queue_rx(8'h7A);
        queue_rx(CH_LF);
        wait_idle();

        // Limit zero: line consumed, nothing delivered.
        write_limit(6'd0);
        queue_rx(8'h61);
        queue_rx(8'h62);
        queue_rx(CH_LF);
        wait_idle();

        // Random phases across several limit settings.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       phase_limit = 6'd63;
                1:       phase_limit = 6'd1;
                2:       phase_limit = 6'd2;
                3:       phase_limit = 6'd7;
                4:       phase_limit = LEN_W'($urandom_range(3, 12));
                default: phase_limit = 6'd63;
            endcase
            wait_idle();
            write_limit(phase_limit);
            steady <= (p == 2 || p == 5);
            if (p == 5)
                hold_asked <= hold_asked + 1;

            start_count = 0;
            if (p == 3)
            begin
                // a short line, then the sender waits for its characters
                queue_line(4, 1'b0);
                drain_next = 1'b1;
            end
            if (p == 4)
            begin
                // longer than the limit, then a full-store overflow, then
                // a short line to show the mark was cleared
                queue_line(int'(phase_limit) + 1 + int'($urandom_range(0, 3)), 1'b1);
                queue_line(STORE_CAP + 1 + int'($urandom_range(0, 3)), 1'b0);
                queue_line(3, 1'b0);
            end
            if (p == 5)
                queue_line(STORE_CAP, 1'b0);   // store exactly full, no overflow

            while (start_count < 6)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    line_len = $urandom_range(1, 4);
                    queue_noise(line_len);
                end
                else
                begin
                    line_len = pick_line_len();
                    queue_line(line_len, 1'b1);
                    line_len++;
                end
                start_count += line_len;
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("tb_text_line_assembler_unit passed");
        else
            $display("tb_text_line_assembler_unit failed");
        $finish;
    end

endmodule
